// ===== rtl/oli_pkg.sv =====
`timescale 1ns / 1ps

package oli_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned DEF_CAPACITY = 16;

  localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PREPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DUMP    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  // one command per cycle, shared by every cell of the chain
  typedef struct packed {
    logic app;  // cell at index count loads the item
    logic pre;  // shift toward the tail, cell 0 loads the item
    logic rot;  // shift toward the head, cell count-1 takes the head
    logic del;  // shift toward the head, head is dropped
  } cell_cmd_t;

endpackage

// ===== rtl/oli_cell.sv =====
`timescale 1ns / 1ps

module oli_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic                         clk,
  input  oli_pkg::cell_cmd_t           cmd,
  input  logic [CW-1:0]                count,
  input  logic [oli_pkg::DATA_W-1:0]   item,
  input  logic [oli_pkg::DATA_W-1:0]   left_val,
  input  logic [oli_pkg::DATA_W-1:0]   right_val,
  input  logic [oli_pkg::DATA_W-1:0]   head_val,
  output logic [oli_pkg::DATA_W-1:0]   val
);
  import oli_pkg::*;

  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (cmd.app && count == MY_IDX) begin
      val_nxt = item;
    end else if (cmd.pre) begin
      val_nxt = left_val;
    end else if (cmd.rot) begin
      val_nxt = (count == MY_NEXT) ? head_val : right_val;
    end else if (cmd.del) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== rtl/ordered_list_insert_delete.sv =====
`timescale 1ns / 1ps

// channel  | dir | tdata                                   | tuser       | tlast
// in_      | in  | [31:0] item_value                       | [1:0] mode  | -
// out_     | out | [31:0] entry_value, [38:32] position    | [1:0] status| last
//
// append and prepend load or shift the cell chain in one step
// delete and dump walk the list by rotating the chain one cell per cycle while the
// output register can take a beat, over entry_count steps (at most CAPACITY); the
// head cell is compared or emitted each step, and a delete drops the first matching head
// each walk step waits while the output register holds an untaken beat
// reset (synchronous, rst_n low) empties the list; cell contents are not cleared

module ordered_list_insert_delete #(
  parameter int unsigned CAPACITY = oli_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [oli_pkg::DATA_W-1:0]         in_tdata,   // [31:0] item_value
  input  logic [oli_pkg::MODE_W-1:0]         in_tuser,   // [1:0] mode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [oli_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [31:0] entry_value, [38:32] position
  output logic [oli_pkg::STAT_W-1:0]         out_tuser,  // [1:0] status
  output logic                               out_tlast
);
  import oli_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  // control state
  logic              state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     len_r, len_nxt;     // walk length, count at start of the walk
  logic [CW-1:0]     step_r, step_nxt;
  logic              dump_r, dump_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [DATA_W-1:0] item_r, item_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic              out_last_r, out_last_nxt;

  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [DATA_W-1:0] head;

  logic slot_free, in_fire, walk_go, hit, walk_end, is_full;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;
  assign walk_go   = (state_r == S_WALK) && slot_free;
  assign head      = cell_val[0];
  assign hit       = !dump_r && !found_r && (head == item_r);
  assign walk_end  = (step_r == len_r - CW'(1));
  assign is_full   = (count_r == CAP_C);

  // command to the chain
  always_comb begin
    cmd = '0;
    if (in_fire && !is_full) begin
      cmd.app = (in_tuser == MODE_APPEND);
      cmd.pre = (in_tuser == MODE_PREPEND);
    end
    if (walk_go) begin
      cmd.del = hit;
      cmd.rot = !hit;
    end
  end

  // chain of cells, each one slot of the list in order
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = in_tdata;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    oli_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .item      (in_tdata),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (head),
      .val       (cell_val[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    len_nxt        = len_r;
    step_nxt       = step_r;
    dump_nxt       = dump_r;
    found_nxt      = found_r;
    item_nxt       = item_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;

    if (in_fire) begin
      if (in_tuser inside {MODE_APPEND, MODE_PREPEND}) begin
        // insert gives one beat right away
        out_valid_nxt  = 1'b1;
        out_status_nxt = is_full ? ST_FULL : ST_OK;
        out_value_nxt  = '0;
        out_pos_nxt    = '0;
        out_last_nxt   = 1'b1;
        if (!is_full) begin
          count_nxt = count_r + CW'(1);
        end
      end else if (count_r == '0) begin
        // delete or dump on an empty list
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_EMPTY;
        out_value_nxt  = '0;
        out_pos_nxt    = '0;
        out_last_nxt   = 1'b1;
      end else begin
        state_nxt = S_WALK;
        len_nxt   = count_r;
        step_nxt  = '0;
        dump_nxt  = (in_tuser == MODE_DUMP);
        found_nxt = 1'b0;
        item_nxt  = in_tdata;
      end
    end

    if (walk_go) begin
      step_nxt = step_r + CW'(1);
      if (hit) begin
        found_nxt = 1'b1;
        count_nxt = count_r - CW'(1);
      end
      if (dump_r) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_value_nxt  = head;
        out_pos_nxt    = POS_W'(step_r) + POS_W'(1);
        out_last_nxt   = walk_end;
      end else if (walk_end) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = (found_r || hit) ? ST_OK : ST_MISSING;
        out_value_nxt  = '0;
        out_pos_nxt    = '0;
        out_last_nxt   = 1'b1;
      end
      if (walk_end) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      len_r       <= '0;
      step_r      <= '0;
      dump_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      step_r      <= step_nxt;
      dump_r      <= dump_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pos_r, out_value_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/oli_checker.sv =====
`timescale 1ns / 1ps

module oli_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [oli_pkg::MODE_W-1:0]         in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [oli_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic [oli_pkg::STAT_W-1:0]         out_tuser,
  input logic                               out_tlast
);
  import oli_pkg::*;

  // no beat accepted while an untaken result blocks the output register
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && out_tvalid |-> out_tready)
    else $error("input accepted while output stalled");

  // an insert answers in the next cycle with a single beat
  a_insert_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_APPEND || in_tuser == MODE_PREPEND)
    |=> out_tvalid && out_tlast && out_tdata == '0
        && (out_tuser == ST_OK || out_tuser == ST_FULL))
    else $error("insert result malformed");

  // any status other than ok is a lone beat without payload
  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tlast && out_tdata == '0)
    else $error("error status beat carries payload");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat dropped under stall");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind ordered_list_insert_delete oli_checker u_oli_checker (.*);

// ===== sim/ordered_list_insert_delete_tb.sv =====
`timescale 1ns / 1ps

module ordered_list_insert_delete_tb;
  import oli_pkg::*;

  localparam int unsigned CAP        = DEF_CAPACITY;
  localparam int unsigned STALL_LIMIT = 20000;  // cycles with no beat on either side

  // one result beat as seen on the out_ channel
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
    logic              last;
  } list_beat_t;

  // mirror of the list contents plus the queue of beats the block still owes us
  class list_tracker;
    logic [DATA_W-1:0] stored_q[$];
    list_beat_t        owed_beats[$];
    int unsigned       mismatches;
    int unsigned       commands;
    int unsigned       beats_checked;
    int unsigned       full_refusals;
    int unsigned       empty_hits;
    int unsigned       missing_hits;
    int unsigned       longest_dump;

    function void owe(logic [STAT_W-1:0] status, logic [DATA_W-1:0] value,
                      logic [POS_W-1:0] position, logic last);
      list_beat_t b;
      b.status   = status;
      b.value    = value;
      b.position = position;
      b.last     = last;
      owed_beats.push_back(b);
    endfunction

    function int unsigned pending();
      return owed_beats.size();
    endfunction

    // apply one accepted command to the mirror and queue what it must produce
    function void note_command(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
      int hit;
      hit = -1;
      commands++;
      case (mode)
        MODE_APPEND, MODE_PREPEND: begin
          if (stored_q.size() >= CAP) begin
            full_refusals++;
            owe(ST_FULL, '0, '0, 1'b1);
          end else begin
            if (mode == MODE_APPEND) stored_q.push_back(value);
            else stored_q.push_front(value);
            owe(ST_OK, '0, '0, 1'b1);
          end
        end
        MODE_DELETE: begin
          if (stored_q.size() == 0) begin
            empty_hits++;
            owe(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            // first match nearest the head
            for (int i = 0; i < stored_q.size(); i++) begin
              if (hit < 0 && stored_q[i] == value) hit = i;
            end
            if (hit < 0) begin
              missing_hits++;
              owe(ST_MISSING, '0, '0, 1'b1);
            end else begin
              stored_q.delete(hit);
              owe(ST_OK, '0, '0, 1'b1);
            end
          end
        end
        default: begin
          if (stored_q.size() == 0) begin
            empty_hits++;
            owe(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            if (stored_q.size() > longest_dump) longest_dump = stored_q.size();
            for (int i = 0; i < stored_q.size(); i++)
              owe(ST_OK, stored_q[i], POS_W'(i + 1), (i == stored_q.size() - 1));
          end
        end
      endcase
    endfunction

    function void check_beat(logic [OUT_TDATA_W-1:0] tdata, logic [STAT_W-1:0] status,
                             logic tlast);
      list_beat_t want;
      beats_checked++;
      if (owed_beats.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat status=%0d value=%h pos=%0d last=%0b",
                 $time, status, tdata[31:0], tdata[38:32], tlast);
        return;
      end
      want = owed_beats.pop_front();
      if (status !== want.status) begin
        mismatches++;
        $display("%0t: status expected %0d got %0d", $time, want.status, status);
      end
      if (tdata[31:0] !== want.value) begin
        mismatches++;
        $display("%0t: entry value expected %h got %h", $time, want.value, tdata[31:0]);
      end
      if (tdata[38:32] !== want.position) begin
        mismatches++;
        $display("%0t: position expected %0d got %0d", $time, want.position,
                 tdata[38:32]);
      end
      if (tlast !== want.last) begin
        mismatches++;
        $display("%0t: last expected %0b got %0b", $time, want.last, tlast);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata;   // [31:0] item_value
  logic [MODE_W-1:0]      in_tuser;   // [1:0] mode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [31:0] entry_value, [38:32] position
  logic [STAT_W-1:0]      out_tuser;  // [1:0] status
  logic                   out_tlast;

  list_tracker tracker;
  int unsigned idle_in_pct;   // chance per cycle that the sender holds off
  int unsigned idle_out_pct;  // chance per cycle that the receiver stalls
  int unsigned quiet_cycles;

  ordered_list_insert_delete #(
    .CAPACITY (CAP)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= idle_out_pct);
  end

  // beat monitor: check the result first so a beat never meets its own command
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_beat(out_tdata, out_tuser, out_tlast);
      if (in_tvalid && in_tready) tracker.note_command(in_tuser, in_tdata);
    end
  end

  // watchdog on cycles where nothing moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // hand one command to the block; in_tvalid stays high into the next call
  task automatic send_cmd(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
    while ($urandom_range(99) < idle_in_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  // sender holds off until every owed beat has been taken
  task automatic drain_list();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // half the values come from a small pool so deletes find matches and duplicates form
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] pool[6];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0005, 32'hDEAD_BEEF};
    if ($urandom_range(1)) return pool[$urandom_range(5)];
    return $urandom;
  endfunction

  // random commands in alternating grow and shrink stretches
  task automatic random_cmds(int unsigned count);
    int unsigned roll;
    logic        grow;
    logic [DATA_W-1:0] v;
    grow = 1'b1;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 20 == 19) grow = !grow;
      roll = $urandom_range(99);
      v    = pick_value();
      if (grow ? (roll < 70) : (roll < 20)) begin
        send_cmd($urandom_range(1) ? MODE_APPEND : MODE_PREPEND, v);
      end else if (grow ? (roll < 85) : (roll < 80)) begin
        // mostly delete something that is really stored
        if (tracker.stored_q.size() != 0 && $urandom_range(3) != 0)
          v = tracker.stored_q[$urandom_range(tracker.stored_q.size() - 1)];
        send_cmd(MODE_DELETE, v);
      end else begin
        send_cmd(MODE_DUMP, v);
      end
    end
  endtask

  initial begin
    tracker      = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = MODE_APPEND;
    idle_in_pct  = 38;
    idle_out_pct = 86;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: dump and delete both report empty
    send_cmd(MODE_DUMP, 32'h0);
    send_cmd(MODE_DELETE, 32'h0);
    // removing the only entry leaves an empty list
    send_cmd(MODE_APPEND, 32'h8000_0000);
    send_cmd(MODE_DELETE, 32'h8000_0000);
    send_cmd(MODE_DUMP, 32'hFFFF_FFFF);
    // extremes and a duplicate, one copy at the head and one further down
    send_cmd(MODE_APPEND, 32'h7FFF_FFFF);
    send_cmd(MODE_PREPEND, 32'h8000_0000);
    send_cmd(MODE_APPEND, 32'h0000_0000);
    send_cmd(MODE_APPEND, 32'hFFFF_FFFF);
    send_cmd(MODE_PREPEND, 32'h7FFF_FFFF);
    send_cmd(MODE_DUMP, 32'h0);
    // delete hits the copy nearest the head, then a missing value, then the tail
    send_cmd(MODE_DELETE, 32'h7FFF_FFFF);
    send_cmd(MODE_DELETE, 32'h1234_5678);
    send_cmd(MODE_DELETE, 32'hFFFF_FFFF);
    send_cmd(MODE_DUMP, 32'h0);
    // fill up, then both inserts are refused and a full-length dump follows
    while (tracker.stored_q.size() < CAP)
      send_cmd(tracker.stored_q.size() % 2 ? MODE_APPEND : MODE_PREPEND,
               32'h5555_0000 | tracker.stored_q.size());
    send_cmd(MODE_APPEND, 32'hAAAA_AAAA);
    send_cmd(MODE_PREPEND, 32'h5555_5555);
    send_cmd(MODE_DUMP, 32'h0);

    drain_list();
    random_cmds(56);

    idle_in_pct  = 86;
    idle_out_pct = 38;
    random_cmds(56);

    idle_in_pct  = 0;
    idle_out_pct = 0;
    random_cmds(56);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (4 * CAP) @(posedge clk);

    $display("ran %0d commands, checked %0d result beats, longest dump %0d entries",
             tracker.commands, tracker.beats_checked, tracker.longest_dump);
    $display("full refusals %0d, empty-list replies %0d, not-found replies %0d",
             tracker.full_refusals, tracker.empty_hits, tracker.missing_hits);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/oli_pkg.sv
rtl/oli_cell.sv
rtl/ordered_list_insert_delete.sv
rtl/oli_checker.sv
sim/ordered_list_insert_delete_tb.sv
